>>> hw/rtl/stst_pkg.sv
package stst_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    KIND_CHECK     = 3'd0,
    KIND_VIOLATION = 3'd1,
    KIND_DECAY     = 3'd2,
    KIND_UNBAN     = 3'd3,
    KIND_WHITELIST = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CFG_THREAT = 3'd0,
    CFG_ATTACK = 3'd1,
    CFG_PERM   = 3'd2,
    CFG_MAXTB  = 3'd3,
    CFG_SHORT  = 3'd4,
    CFG_LONG   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_ALLOWED     = 2'd0,
    ST_BLOCKED     = 2'd1,
    ST_WHITELISTED = 2'd2
  } ip_status_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic        whitelisted;
    logic        permanent;
    logic        temp_present;
    logic [31:0] ban_until;
    logic [15:0] score;
    logic [7:0]  ban_count;
    logic [31:0] connections;
  } entry_t;

  typedef struct packed {
    logic [15:0] threat;
    logic [15:0] attack;
    logic [15:0] perm;
    logic [7:0]  max_tb;
    logic [23:0] short_s;
    logic [23:0] long_s;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] ip;
    logic [3:0]  vtype;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [1:0]  ip_status;
    logic [15:0] score_now;
    logic [7:0]  ban_count_now;
    logic        is_permanent;
    logic        is_temp_banned;
    logic        new_permanent;
    logic        new_temp_ban;
    logic        table_full;
  } result_t;

  function automatic logic [7:0] kind_score(input logic [3:0] v);
    case (v)
      4'd0: return 8'd10;
      4'd1: return 8'd5;
      4'd2: return 8'd20;
      4'd3: return 8'd50;
      4'd4: return 8'd30;
      4'd5: return 8'd15;
      4'd6: return 8'd10;
      4'd7: return 8'd100;
      default: return 8'd5;
    endcase
  endfunction

  function automatic logic [31:0] ban_end(input logic [31:0] now, input logic [23:0] dur);
    logic [32:0] s;
    s = {1'b0, now} + {9'd0, dur};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> hw/rtl/source_threat_score_table_top.sv
// Source threat score table.
// Input channel s_axis: one word per item: kind, address, violation type, time.
// Output channel m_axis: exactly one result word per item, in order.
// Configuration channel cfg: register index and data, taken any cycle; write it
// only while no item is in flight.
// Entries sit in a ring of TABLE_ENTRIES cells that rotates one step a cycle
// while an item is busy. A scan turns the ring once around, decaying each
// entry as it passes cell 0 on a decay item. The ring then turns on until the
// matched or free entry is back at the head and takes the updated entry there.
// A decay item or a miss on a full table is done as soon as the scan ends.
// The next item is taken the cycle after the result moves to the output register,
// even while that result is still waiting on m_axis_tready.
// During a stall the result holds, and s_axis_tready stays low once a second
// result is ready.
// Reset clears all entries and restores default register values at once.
module source_threat_score_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata, // kind[2:0], ip_address[34:3], violation_type[38:35],
                                    // now_seconds[70:39], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata, // ip_status[1:0], score_now[17:2], ban_count_now[25:18],
                                    // is_permanent[26], is_temp_banned[27],
                                    // new_permanent[28], new_temp_ban[29], table_full[30], pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import stst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  cfg_t cfg;
  item_t item;
  entry_t ring [TABLE_ENTRIES];
  entry_t cell_din [TABLE_ENTRIES];
  entry_t ring_in;
  entry_t hit;
  entry_t upd;
  entry_t head;
  logic [IDX_W:0] cnt;
  logic found, free_seen, write_en, shift;
  logic is_match, is_free;
  logic at_target, decay_on;
  logic [IDX_W-1:0] hit_pos;
  logic [IDX_W-1:0] free_pos;
  result_t res;
  result_t res_q;
  logic res_pend;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE) && !res_pend;
  assign shift = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threat <= 16'd30;
      cfg.attack <= 16'd60;
      cfg.perm <= 16'd100;
      cfg.max_tb <= 8'd3;
      cfg.short_s <= 24'd3600;
      cfg.long_s <= 24'd86400;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THREAT: cfg.threat <= cfg_data[15:0];
        CFG_ATTACK: cfg.attack <= cfg_data[15:0];
        CFG_PERM:   cfg.perm <= cfg_data[15:0];
        CFG_MAXTB:  cfg.max_tb <= cfg_data[7:0];
        CFG_SHORT:  cfg.short_s <= cfg_data;
        CFG_LONG:   cfg.long_s <= cfg_data;
        default: ;
      endcase
    end
  end

  // cell 0 receives the last cell; the head cell of the ring is ring[TABLE_ENTRIES-1]
  assign head = ring[TABLE_ENTRIES-1];
  assign is_match = head.valid && head.address == item.ip;
  assign is_free = !head.valid;
  assign at_target = (state == S_DONE) && (cnt[IDX_W-1:0] == (found ? hit_pos : free_pos));
  assign decay_on = (state == S_SCAN) && (item.kind == KIND_DECAY);

  always_comb begin
    ring_in = head;
    if (at_target && write_en) ring_in = upd;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign cell_din[g] = ring_in;
      end else begin : g_next
        assign cell_din[g] = ring[g-1];
      end
      stst_cell u_cell (
        .clk(clk), .rst(rst), .shift(shift),
        .decay(g == 0 ? decay_on : 1'b0),
        .now(item.now),
        .din(cell_din[g]),
        .dout(ring[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      res_pend <= 1'b0;
      m_axis_tvalid <= 1'b0;
      found <= 1'b0;
      free_seen <= 1'b0;
    end else begin
      if (res_pend && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {1'b0, res_q.table_full, res_q.new_temp_ban, res_q.new_permanent,
                         res_q.is_temp_banned, res_q.is_permanent, res_q.ban_count_now,
                         res_q.score_now, res_q.ip_status};
        res_pend <= 1'b0;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          item.kind <= s_axis_tdata[2:0];
          item.ip <= s_axis_tdata[34:3];
          item.vtype <= s_axis_tdata[38:35];
          item.now <= s_axis_tdata[70:39];
          state <= S_SCAN;
          cnt <= '0;
          found <= 1'b0;
          free_seen <= 1'b0;
        end
        S_SCAN: begin
          if (is_match && !found) begin
            found <= 1'b1;
            hit <= head;
            hit_pos <= cnt[IDX_W-1:0];
          end else if (is_free && !free_seen) begin
            free_seen <= 1'b1;
            free_pos <= cnt[IDX_W-1:0];
          end
          cnt <= cnt + 1'b1;
          if (cnt == (IDX_W+1)'(TABLE_ENTRIES - 1)) begin
            state <= S_DONE;
            cnt <= '0;
          end
        end
        S_DONE: begin
          if (cnt == '0 && !found && free_seen) hit <= '0;
          cnt <= cnt + 1'b1;
          if (at_target || (!found && !free_seen) || item.kind == KIND_DECAY) begin
            state <= S_IDLE;
            res_q <= item.kind == KIND_DECAY ? '0 : res;
            res_pend <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  stst_update u_update (
    .item(item), .cfg(cfg), .found(found), .free_seen(free_seen),
    .cur(found ? hit : '0), .upd(upd), .write_en(write_en), .res(res)
  );

  a_one_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result lost");
endmodule

>>> hw/rtl/stst_cell.sv
module stst_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            decay,
  input  logic [31:0]     now,
  input  stst_pkg::entry_t din,
  output stst_pkg::entry_t dout
);
  import stst_pkg::*;

  entry_t e;
  entry_t e_next;
  logic [38:0] quot;

  always_comb begin
    e_next = din;
    quot = 39'(din.score) * 39'd7549749;
    if (decay && din.valid) begin
      e_next.score = quot[38:23];
      if (din.temp_present && now >= din.ban_until) e_next.temp_present = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e.valid <= 1'b0;
      e.whitelisted <= 1'b0;
      e.permanent <= 1'b0;
      e.temp_present <= 1'b0;
    end else if (shift) begin
      e.valid <= e_next.valid;
      e.whitelisted <= e_next.whitelisted;
      e.permanent <= e_next.permanent;
      e.temp_present <= e_next.temp_present;
    end
    if (shift) begin
      e.address <= e_next.address;
      e.ban_until <= e_next.ban_until;
      e.score <= e_next.score;
      e.ban_count <= e_next.ban_count;
      e.connections <= e_next.connections;
    end
  end

  assign dout = e;
endmodule

>>> hw/rtl/stst_update.sv
module stst_update (
  input  stst_pkg::item_t   item,
  input  stst_pkg::cfg_t    cfg,
  input  logic              found,
  input  logic              free_seen,
  input  stst_pkg::entry_t  cur,
  output stst_pkg::entry_t  upd,
  output logic              write_en,
  output stst_pkg::result_t res
);
  import stst_pkg::*;

  entry_t e;
  logic [16:0] s;
  logic [15:0] sc;
  logic ok;

  always_comb begin
    res = '0;
    write_en = 1'b0;
    e = cur;
    s = '0;
    sc = '0;
    ok = found || free_seen;
    if (!found) begin
      e = '0;
      e.valid = 1'b1;
      e.address = item.ip;
    end
    case (item.kind)
      KIND_CHECK: begin
        if (found && cur.whitelisted) res.ip_status = ST_WHITELISTED;
        else if (found && cur.permanent) res.ip_status = ST_BLOCKED;
        else if (found && cur.temp_present && item.now < cur.ban_until)
          res.ip_status = ST_BLOCKED;
        else if (!ok) res.table_full = 1'b1;
        else begin
          e.temp_present = 1'b0;
          e.connections = e.connections + 32'd1;
          write_en = 1'b1;
        end
      end
      KIND_VIOLATION: begin
        if (!ok) res.table_full = 1'b1;
        else begin
          write_en = 1'b1;
          s = {1'b0, e.score} + {9'd0, kind_score(item.vtype)};
          sc = s[16] ? 16'hFFFF : s[15:0];
          e.score = sc;
          if (sc >= cfg.perm) begin
            if (!e.permanent) begin
              e.permanent = 1'b1;
              res.new_permanent = 1'b1;
            end
          end else begin
            if ((sc >= cfg.attack || sc >= cfg.threat) && !e.temp_present) begin
              e.temp_present = 1'b1;
              e.ban_until = ban_end(item.now,
                                    (sc >= cfg.attack) ? cfg.long_s : cfg.short_s);
              if (e.ban_count != 8'hFF) e.ban_count = e.ban_count + 8'd1;
              res.new_temp_ban = 1'b1;
            end
            if (e.ban_count >= cfg.max_tb && !e.permanent) begin
              e.permanent = 1'b1;
              res.new_permanent = 1'b1;
            end
          end
        end
      end
      KIND_UNBAN: begin
        if (found) begin
          write_en = 1'b1;
          e.permanent = 1'b0;
          e.temp_present = 1'b0;
          e.score = '0;
          e.ban_count = '0;
        end
      end
      KIND_WHITELIST: begin
        if (!ok) res.table_full = 1'b1;
        else begin
          write_en = 1'b1;
          e.whitelisted = 1'b1;
        end
      end
      default: ;
    endcase
    if (item.kind inside {KIND_CHECK, KIND_VIOLATION, KIND_UNBAN, KIND_WHITELIST} &&
        !res.table_full && (found || write_en)) begin
      res.score_now = e.score;
      res.ban_count_now = e.ban_count;
      res.is_permanent = e.permanent;
      res.is_temp_banned = e.temp_present;
    end
    upd = e;
  end
endmodule

>>> tb/sv/stst_checker.sv
`timescale 1ns / 1ps

module stst_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          errors,
  output int          pending
);
  import stst_pkg::*;

  logic [15:0] thr_threat, thr_attack, thr_perm;
  logic [7:0]  thr_max_tb;
  logic [23:0] dur_short, dur_long;

  logic        tbl_valid       [TABLE_ENTRIES];
  logic [31:0] tbl_address     [TABLE_ENTRIES];
  logic        tbl_whitelisted [TABLE_ENTRIES];
  logic        tbl_perm        [TABLE_ENTRIES];
  logic        tbl_temp        [TABLE_ENTRIES];
  logic [31:0] tbl_until       [TABLE_ENTRIES];
  logic [15:0] tbl_score       [TABLE_ENTRIES];
  logic [7:0]  tbl_bans        [TABLE_ENTRIES];
  logic [31:0] tbl_conns       [TABLE_ENTRIES];

  result_t verdict_q[$];

  function automatic int lookup_source(logic [31:0] ip);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_address[i] == ip) return i;
    return -1;
  endfunction

  function automatic int claim_source(logic [31:0] ip);
    int i;
    i = lookup_source(ip);
    if (i >= 0) return i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_address[i] = ip;
        tbl_whitelisted[i] = 1'b0;
        tbl_perm[i] = 1'b0;
        tbl_temp[i] = 1'b0;
        tbl_until[i] = '0;
        tbl_score[i] = '0;
        tbl_bans[i] = '0;
        tbl_conns[i] = '0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void start_temp_ban(int i, logic [31:0] now, logic [23:0] dur,
                                         inout result_t r);
    logic [32:0] fin;
    if (tbl_temp[i]) return;
    fin = {1'b0, now} + {9'd0, dur};
    tbl_temp[i] = 1'b1;
    tbl_until[i] = fin[32] ? 32'hFFFF_FFFF : fin[31:0];
    if (tbl_bans[i] != 8'hFF) tbl_bans[i] = tbl_bans[i] + 8'd1;
    r.new_temp_ban = 1'b1;
  endfunction

  function automatic void enforce_limits(int i, logic [31:0] now, inout result_t r);
    logic [15:0] s;
    s = tbl_score[i];
    if (s >= thr_perm) begin
      if (!tbl_perm[i]) begin
        tbl_perm[i] = 1'b1;
        r.new_permanent = 1'b1;
      end
      return;
    end
    if (s >= thr_attack) start_temp_ban(i, now, dur_long, r);
    else if (s >= thr_threat) start_temp_ban(i, now, dur_short, r);
    if (tbl_bans[i] >= thr_max_tb && !tbl_perm[i]) begin
      tbl_perm[i] = 1'b1;
      r.new_permanent = 1'b1;
    end
  endfunction

  function automatic logic [7:0] violation_weight(logic [3:0] v);
    case (v)
      4'd0, 4'd6: return 8'd10;
      4'd2:       return 8'd20;
      4'd3:       return 8'd50;
      4'd4:       return 8'd30;
      4'd5:       return 8'd15;
      4'd7:       return 8'd100;
      default:    return 8'd5;
    endcase
  endfunction

  function automatic void fill_entry(int i, inout result_t r);
    if (i < 0) return;
    r.score_now = tbl_score[i];
    r.ban_count_now = tbl_bans[i];
    r.is_permanent = tbl_perm[i];
    r.is_temp_banned = tbl_temp[i];
  endfunction

  function automatic result_t admit_source(logic [79:0] w);
    result_t r;
    logic [2:0]  kind;
    logic [31:0] ip, now;
    logic [3:0]  vt;
    logic [16:0] sum;
    int i;
    r = '0;
    kind = w[2:0];
    ip = w[34:3];
    vt = w[38:35];
    now = w[70:39];
    case (kind)
      KIND_CHECK: begin
        i = lookup_source(ip);
        if (i >= 0 && tbl_whitelisted[i]) r.ip_status = ST_WHITELISTED;
        else if (i >= 0 && tbl_perm[i]) r.ip_status = ST_BLOCKED;
        else if (i >= 0 && tbl_temp[i] && now < tbl_until[i]) r.ip_status = ST_BLOCKED;
        else begin
          if (i >= 0) tbl_temp[i] = 1'b0;
          i = claim_source(ip);
          if (i < 0) r.table_full = 1'b1;
          else begin
            tbl_conns[i] = tbl_conns[i] + 32'd1;
            r.ip_status = ST_ALLOWED;
          end
        end
        fill_entry(i, r);
      end
      KIND_VIOLATION: begin
        i = claim_source(ip);
        if (i < 0) r.table_full = 1'b1;
        else begin
          sum = {1'b0, tbl_score[i]} + {9'd0, violation_weight(vt)};
          tbl_score[i] = sum[16] ? 16'hFFFF : sum[15:0];
          enforce_limits(i, now, r);
          fill_entry(i, r);
        end
      end
      KIND_DECAY: begin
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
          if (tbl_valid[k]) begin
            tbl_score[k] = 16'((32'(tbl_score[k]) * 9) / 10);
            if (tbl_temp[k] && now >= tbl_until[k]) tbl_temp[k] = 1'b0;
          end
        end
      end
      KIND_UNBAN: begin
        i = lookup_source(ip);
        if (i >= 0) begin
          tbl_perm[i] = 1'b0;
          tbl_temp[i] = 1'b0;
          tbl_score[i] = '0;
          tbl_bans[i] = '0;
        end
        fill_entry(i, r);
      end
      KIND_WHITELIST: begin
        i = claim_source(ip);
        if (i < 0) r.table_full = 1'b1;
        else begin
          tbl_whitelisted[i] = 1'b1;
          fill_entry(i, r);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic match_field(string nm, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      thr_threat = 16'd30;
      thr_attack = 16'd60;
      thr_perm = 16'd100;
      thr_max_tb = 8'd3;
      dur_short = 24'd3600;
      dur_long = 24'd86400;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_address[i] = '0;
        tbl_whitelisted[i] = 1'b0;
        tbl_perm[i] = 1'b0;
        tbl_temp[i] = 1'b0;
        tbl_until[i] = '0;
        tbl_score[i] = '0;
        tbl_bans[i] = '0;
        tbl_conns[i] = '0;
      end
      verdict_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t mismatch: unexpected word %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          e = verdict_q.pop_front();
          match_field("ip_status", e.ip_status, m_axis_tdata[1:0]);
          match_field("score_now", e.score_now, m_axis_tdata[17:2]);
          match_field("ban_count_now", e.ban_count_now, m_axis_tdata[25:18]);
          match_field("is_permanent", e.is_permanent, m_axis_tdata[26]);
          match_field("is_temp_banned", e.is_temp_banned, m_axis_tdata[27]);
          match_field("new_permanent", e.new_permanent, m_axis_tdata[28]);
          match_field("new_temp_ban", e.new_temp_ban, m_axis_tdata[29]);
          match_field("table_full", e.table_full, m_axis_tdata[30]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THREAT: thr_threat = cfg_data[15:0];
          CFG_ATTACK: thr_attack = cfg_data[15:0];
          CFG_PERM:   thr_perm = cfg_data[15:0];
          CFG_MAXTB:  thr_max_tb = cfg_data[7:0];
          CFG_SHORT:  dur_short = cfg_data;
          CFG_LONG:   dur_long = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        verdict_q.insert(verdict_q.size(), admit_source(s_axis_tdata));
      pending = verdict_q.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import stst_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int POOL_N = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  int          errors;
  int          pending;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;
  logic [31:0] clock_s = '0;
  logic [31:0] pool [POOL_N];

  source_threat_score_table_top i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stst_checker i_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic push_word(logic [2:0] kind, logic [31:0] ip, logic [3:0] vt,
                           logic [31:0] now);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {9'd0, now, vt, ip, kind};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic settle;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_limits(logic [23:0] threat, logic [23:0] attack, logic [23:0] perm,
                             logic [23:0] max_tb, logic [23:0] short_s, logic [23:0] long_s);
    logic [23:0] vals [6];
    vals = '{threat, attack, perm, max_tb, short_s, long_s};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] tick_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) clock_s = $urandom;
    else if (r < 8) clock_s = clock_s + $urandom_range(0, 200000);
    else clock_s = clock_s + $urandom_range(0, 3000);
    return clock_s;
  endfunction

  task automatic random_word(logic [31:0] ip);
    int r;
    logic [2:0] kind;
    r = $urandom_range(0, 99);
    if (r < 35) kind = KIND_CHECK;
    else if (r < 75) kind = KIND_VIOLATION;
    else if (r < 83) kind = KIND_DECAY;
    else if (r < 91) kind = KIND_UNBAN;
    else if (r < 95) kind = KIND_WHITELIST;
    else kind = 3'($urandom_range(int'(KIND_WHITELIST) + 1, 7));
    push_word(kind, (kind == KIND_DECAY && r[0]) ? $urandom : ip,
              4'($urandom_range(0, 15)), tick_clock());
  endtask

  task automatic random_run(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 0) steady = ($urandom_range(0, 3) == 0);
      random_word(pool[$urandom_range(0, POOL_N - 1)]);
    end
    steady = 1'b0;
  endtask

  initial begin
    logic [31:0] a, b, c;
    pool[0] = 32'h0;
    pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_N; i++) pool[i] = $urandom;
    a = pool[2];
    b = pool[3];
    c = pool[4];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_word(KIND_CHECK, pool[1], 4'd0, 32'h0);
    push_word(KIND_CHECK, pool[0], 4'd0, 32'hFFFF_FFFF);
    for (int v = 0; v < 9; v++) push_word(KIND_VIOLATION, a, 4'(v), 32'd100);
    push_word(KIND_VIOLATION, b, 4'd15, 32'd100);
    push_word(KIND_CHECK, a, 4'd0, 32'd200);
    push_word(KIND_UNBAN, a, 4'd0, 32'd300);
    push_word(KIND_UNBAN, 32'h1234_5678, 4'd0, 32'd300);
    push_word(KIND_VIOLATION, c, 4'd4, 32'hFFFF_FFF0);
    push_word(KIND_CHECK, c, 4'd0, 32'hFFFF_FFF1);
    push_word(KIND_DECAY, 32'h0, 4'd0, 32'hFFFF_FFFF);
    push_word(KIND_CHECK, c, 4'd0, 32'hFFFF_FFFF);
    push_word(KIND_WHITELIST, b, 4'd0, 32'd400);
    push_word(KIND_CHECK, b, 4'd0, 32'd500);
    push_word(3'd5, a, 4'd8, 32'd600);
    push_word(3'd7, a, 4'd15, 32'd600);
    clock_s = 32'd1000;
    settle();

    random_run(300);
    settle();
    load_limits(24'($urandom_range(10, 60)), 24'($urandom_range(40, 120)),
                24'($urandom_range(100, 300)), 24'($urandom_range(1, 6)),
                24'($urandom_range(0, 5000)), 24'($urandom_range(0, 100000)));
    random_run(300);
    settle();
    load_limits(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
    random_run(200);
    settle();
    load_limits(24'($urandom_range(0, 40)), 24'($urandom_range(0, 80)),
                24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'($urandom_range(0, 24'hFFFFFF)));
    random_run(300);
    settle();
    load_limits(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    for (int k = 0; k < 700; k++) begin
      if (k % 50 == 0) steady = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) != 0) push_word(KIND_VIOLATION, c, 4'd7, tick_clock());
      else random_word(pool[$urandom_range(0, POOL_N - 1)]);
    end
    steady = 1'b0;
    settle();
    load_limits(24'd30, 24'd60, 24'd100, 24'd3, 24'd3600, 24'd86400);
    for (int k = 0; k < 120; k++) begin
      if ($urandom_range(0, 3) == 0) random_word(pool[$urandom_range(0, POOL_N - 1)]);
      else random_word($urandom);
    end
    settle();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/stst_pkg.sv
hw/rtl/stst_cell.sv
hw/rtl/stst_update.sv
hw/rtl/source_threat_score_table_top.sv
tb/sv/stst_checker.sv
tb/sv/tb.sv
